[rtl/core/magma_pkg.sv]
// Magma cipher package: S-boxes, round function and round key schedule.
`default_nettype none

package magma_pkg;

   localparam int NumRounds = 32;
   localparam int NumKeys   = 8;
   localparam int HalfW     = 32;
   localparam int KeyIdxW   = $clog2(NumKeys);
   localparam int RotL      = 11;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } op_type;

   localparam logic [3:0] SBOX [8][16] = '{
      '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
        4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
      '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
        4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
      '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
        4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
      '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
        4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
      '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
        4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
      '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
        4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
      '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
        4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
      '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
        4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
   };

   // g = rotl11(S(half + rk))
   function automatic logic [HalfW-1:0] magma_round(input logic [HalfW-1:0] half,
                                                    input logic [HalfW-1:0] rk);
      logic [HalfW-1:0] sum;
      logic [HalfW-1:0] sub;
      sum = half + rk;
      sub = '0;
      for (int n = 0; n < 8; n++) begin
         sub[4*n +: 4] = SBOX[n][sum[4*n +: 4]];
      end
      return {sub[HalfW-RotL-1:0], sub[HalfW-1:HalfW-RotL]};
   endfunction

   function automatic logic [KeyIdxW-1:0] key_idx(input int rnd, input logic dec);
      int k;
      if (dec) begin
         k = (rnd < NumKeys) ? rnd : (NumKeys - 1 - (rnd % NumKeys));
      end else begin
         k = (rnd < NumRounds - NumKeys) ? (rnd % NumKeys) : (NumRounds - 1 - rnd);
      end
      return k[KeyIdxW-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/core/magma_block_cipher.sv]
// Magma block cipher: 32-stage unrolled round pipeline with APB key registers.
// Each accepted request passes through the stages in order, one round per stage, to rsp_valid.
// Throughput: one block per cycle; the whole pipeline holds while a response stalls.
// A stalled response stalls requests only when its output register is full.
// Reset: synchronous, active high; clears all stage valid bits and the key words.
`default_nettype none

module magma_block_cipher
   import magma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic        req_func,
   input  wire logic [63:0] req_block_in,

   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [63:0] rsp_block_out,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   logic [HalfW-1:0] key_ff [NumKeys];
   logic [KeyIdxW-1:0] csr_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[KeyIdxW+1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = key_ff[csr_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumKeys; k++) begin
            key_ff[k] <= '0;
         end
      end else if (csr_wr) begin
         key_ff[csr_idx] <= csr_pwdata;
      end
   end

   // round pipeline
   logic [NumRounds-1:0] vld_ff;
   logic [NumRounds-1:0] vld_in;
   logic [NumRounds-1:0] func_ff;
   logic [NumRounds-1:0] func_in;
   logic [HalfW-1:0]     a1_ff [NumRounds];
   logic [HalfW-1:0]     a1_in [NumRounds];
   logic [HalfW-1:0]     a0_ff [NumRounds];
   logic [HalfW-1:0]     a0_in [NumRounds];
   logic                 adv;

   assign adv       = ~(vld_ff[NumRounds-1] & rsp_stall);
   assign req_stall = ~adv;

   for (genvar r = 0; r < NumRounds; r++) begin : g_round
      localparam logic [KeyIdxW-1:0] KeyEnc = key_idx(r, OP_ENCRYPT);
      localparam logic [KeyIdxW-1:0] KeyDec = key_idx(r, OP_DECRYPT);
      logic             src_vld;
      logic             src_func;
      logic [HalfW-1:0] src_a1;
      logic [HalfW-1:0] src_a0;
      logic [HalfW-1:0] rk;
      logic [HalfW-1:0] g;

      if (r == 0) begin : g_src_in
         assign src_vld  = req_valid;
         assign src_func = req_func;
         assign src_a1   = req_block_in[63:32];
         assign src_a0   = req_block_in[31:0];
      end else begin : g_src_stage
         assign src_vld  = vld_ff[r-1];
         assign src_func = func_ff[r-1];
         assign src_a1   = a1_ff[r-1];
         assign src_a0   = a0_ff[r-1];
      end

      assign rk = (src_func == OP_DECRYPT) ? key_ff[KeyDec] : key_ff[KeyEnc];
      assign g  = magma_round(src_a0, rk);

      always_comb begin
         vld_in[r]  = src_vld;
         func_in[r] = src_func;
         if (r == NumRounds - 1) begin
            a1_in[r] = g ^ src_a1;
            a0_in[r] = src_a0;
         end else begin
            a1_in[r] = src_a0;
            a0_in[r] = g ^ src_a1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         func_ff <= func_in;
         for (int s = 0; s < NumRounds; s++) begin
            a1_ff[s] <= a1_in[s];
            a0_ff[s] <= a0_in[s];
         end
      end
   end

   assign rsp_valid     = vld_ff[NumRounds-1];
   assign rsp_block_out = {a1_ff[NumRounds-1], a0_ff[NumRounds-1]};

   // checks
   logic req_acc;
   logic rsp_acc;
   assign req_acc = req_valid & ~req_stall;
   assign rsp_acc = rsp_valid & ~rsp_stall;

   a_occupancy : assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(vld_ff) ==
                $countones($past(vld_ff)) + $past(req_acc) - $past(rsp_acc)))
      else $error("pipeline occupancy mismatch");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid & rsp_stall) |=> ($stable(vld_ff) && $stable(rsp_block_out)))
      else $error("pipeline moved under stall");

   a_no_back_stall : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output stage");

   a_key_write : assert property (@(posedge clock) disable iff (reset)
      csr_wr |=> (key_ff[$past(csr_idx)] == $past(csr_pwdata)))
      else $error("key word write lost");

endmodule

`default_nettype wire
